/* src/adcspi_pkg.sv */
`timescale 1ns / 1ps

package adcspi_pkg;

  // Total bits shifted per transaction: the setup word, then its echo.
  localparam int TRANSFER_BITS = 32;
  localparam int IDX_W         = 6;
  localparam int WORD_W        = 16;
  localparam int TICK_W        = 8;
  localparam int OUT_TDATA_W   = 24;
  localparam int IN_TDATA_W    = 24;

  localparam logic [WORD_W-1:0] ECHO_MARK = 16'h8000;

  typedef enum logic [1:0] {
    PH_SETUP = 2'd0,
    PH_RISE  = 2'd1,
    PH_HIGH  = 2'd2,
    PH_FALL  = 2'd3
  } phase_t;

  // One result beat, before packing onto the stream.
  typedef struct packed {
    logic              echo_error;
    logic [WORD_W-1:0] sample;
    logic              done_res;
    logic              busy_res;
    logic              sclk;
    logic              mosi;
  } result_t;

endpackage

/* src/adcspi_engine.sv */
`timescale 1ns / 1ps

module adcspi_engine (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic                                 cmd,
  input  logic [adcspi_pkg::WORD_W-1:0]        setup_word,
  input  logic                                 miso,
  input  logic [adcspi_pkg::TICK_W-1:0]        phase_ticks,
  output adcspi_pkg::result_t                  res_next
);

  logic [adcspi_pkg::WORD_W-1:0]        sent_word, sent_word_next;
  logic [adcspi_pkg::TRANSFER_BITS-1:0] received_bits, received_bits_next;
  logic [adcspi_pkg::IDX_W-1:0]         bit_index, bit_index_next;
  adcspi_pkg::phase_t                   phase, phase_next;
  logic [adcspi_pkg::TICK_W-1:0]        tick_count, tick_count_next;
  logic                                 active, active_next;
  logic [adcspi_pkg::WORD_W-1:0]        last_sample, last_sample_next;
  logic                                 last_error, last_error_next;

  logic [adcspi_pkg::TICK_W-1:0]        len;
  logic                                 phase_end;
  logic                                 done;
  logic [adcspi_pkg::WORD_W-1:0]        echo;

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_word     <= '0;
      received_bits <= '0;
      bit_index     <= '0;
      phase         <= adcspi_pkg::PH_SETUP;
      tick_count    <= '0;
      active        <= 1'b0;
      last_sample   <= '0;
      last_error    <= 1'b0;
    end else if (accept) begin
      sent_word     <= sent_word_next;
      received_bits <= received_bits_next;
      bit_index     <= bit_index_next;
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      active        <= active_next;
      last_sample   <= last_sample_next;
      last_error    <= last_error_next;
    end
  end

  always_comb begin
    len       = (phase_ticks == '0) ? adcspi_pkg::TICK_W'(1) : phase_ticks;
    phase_end = ({1'b0, tick_count} + 9'd1) >= {1'b0, len};
    echo      = received_bits[adcspi_pkg::WORD_W-1:0] | adcspi_pkg::ECHO_MARK;

    sent_word_next     = sent_word;
    received_bits_next = received_bits;
    bit_index_next     = bit_index;
    phase_next         = phase;
    tick_count_next    = tick_count;
    active_next        = active;
    last_sample_next   = last_sample;
    last_error_next    = last_error;
    done               = 1'b0;

    if (cmd && !active) begin
      sent_word_next     = setup_word;
      received_bits_next = '0;
      bit_index_next     = '0;
      phase_next         = adcspi_pkg::PH_SETUP;
      tick_count_next    = '0;
      active_next        = 1'b1;
    end else if (active) begin
      if (phase_end) begin
        tick_count_next = '0;
        case (phase)
          adcspi_pkg::PH_SETUP: phase_next = adcspi_pkg::PH_RISE;
          adcspi_pkg::PH_RISE: begin
            phase_next         = adcspi_pkg::PH_HIGH;
            received_bits_next = {received_bits[adcspi_pkg::TRANSFER_BITS-2:0], miso};
          end
          adcspi_pkg::PH_HIGH:  phase_next = adcspi_pkg::PH_FALL;
          adcspi_pkg::PH_FALL: begin
            phase_next     = adcspi_pkg::PH_SETUP;
            bit_index_next = bit_index + 1'b1;
            if (bit_index_next >= adcspi_pkg::IDX_W'(adcspi_pkg::TRANSFER_BITS)) begin
              // Received bits do not change in the fall phase, so check the stored word.
              done        = 1'b1;
              active_next = 1'b0;
              if (echo == sent_word) begin
                last_sample_next = received_bits[adcspi_pkg::TRANSFER_BITS-1:adcspi_pkg::WORD_W];
                last_error_next  = 1'b0;
              end else begin
                last_sample_next = '0;
                last_error_next  = 1'b1;
              end
            end
          end
          default: phase_next = adcspi_pkg::PH_SETUP;
        endcase
      end else begin
        tick_count_next = tick_count + 1'b1;
      end
    end

    // Both halves of the frame carry the same word, so only the low four index bits matter.
    res_next.mosi       = active_next & sent_word_next[~bit_index_next[3:0]];
    res_next.sclk       = active_next & ((phase_next == adcspi_pkg::PH_RISE) ||
                                         (phase_next == adcspi_pkg::PH_HIGH));
    res_next.busy_res   = active_next;
    res_next.done_res   = done;
    res_next.sample     = last_sample_next;
    res_next.echo_error = last_error_next;
  end

endmodule

/* src/adcspi_out_stage.sv */
`timescale 1ns / 1ps

module adcspi_out_stage (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  adcspi_pkg::result_t                res,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [adcspi_pkg::OUT_TDATA_W-1:0] m_tdata
);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'b000, res.echo_error, res.sample, res.done_res, res.busy_res,
                  res.sclk, res.mosi};
    end
  end

endmodule

/* src/adc_spi_read_with_echo_check.sv */
`timescale 1ns / 1ps

// SPI mode-0 style master that reads a converter and checks its echo. Each input beat is
// either a time tick (tuser 0) or a start command (tuser 1) carrying the setup word; a
// start while a transfer runs counts as a plain tick. The setup word goes out twice, MSB
// first, each bit spread over four phases of phase_ticks ticks (0 acts as 1). Every input
// beat yields exactly one result beat showing the line levels and status after that beat.
// The block takes one beat per clock: the state update is one short step between the state
// registers and the output register, and the input is stalled only while the output
// register holds a beat that the sink has not taken. Results appear in the cycle after accept.
module adc_spi_read_with_echo_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [adcspi_pkg::IN_TDATA_W-1:0]    s_tdata,  // setup_word[15:0], miso[16],
                                                         // zero fill
  input  logic                                 s_tuser,  // cmd
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [adcspi_pkg::OUT_TDATA_W-1:0]   m_tdata,  // mosi[0], sclk[1], busy_res[2],
                                                         // done_res[3], sample[19:4],
                                                         // echo_error[20], zero fill
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [7:0]                           cfg_data   // phase_ticks
);

  logic                                 accept;
  logic [adcspi_pkg::TICK_W-1:0]        phase_ticks;
  adcspi_pkg::result_t                  res_next;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= adcspi_pkg::TICK_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      phase_ticks <= cfg_data;
    end
  end

  adcspi_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (s_tuser),
    .setup_word  (s_tdata[15:0]),
    .miso        (s_tdata[16]),
    .phase_ticks (phase_ticks),
    .res_next    (res_next)
  );

  adcspi_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .res      (res_next),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A completed transfer is never still busy.
  assert property (@(posedge clk) disable iff (rst) m_tvalid && m_tdata[3] |-> !m_tdata[2])
    else $error("done beat reports busy");

  // The serial lines only move during a transfer.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[0] || m_tdata[1]) |-> m_tdata[2])
    else $error("mosi or sclk active while idle");

  // A failed echo check reports a zero sample.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[20] |-> (m_tdata[19:4] == 16'h0000))
    else $error("echo error with nonzero sample");

  // The output register takes a new beat on every accepted input.
  assert property (@(posedge clk) disable iff (rst) accept |=> m_tvalid)
    else $error("accepted beat produced no result");

endmodule
